// ===== src/mstpu_pkg.sv =====
// Shared types and constants for the max segment tree point update unit.
// Depends on nothing; the top module and the walker import it.
package mstpu_pkg;

   // Tree geometry
   localparam int MAX_LEAVES = 1024;
   localparam int DEPTH      = 2 * MAX_LEAVES;
   localparam int ADDR_W     = $clog2(DEPTH);

   // Field widths fixed by the interface
   localparam int VAL_W = 48;
   localparam int IDX_W = 10;
   localparam int LC_W  = 11;

   // Reset value of every node and count after reset, and the root and last store addresses
   localparam logic [VAL_W-1:0]  VAL_MIN   = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic [LC_W-1:0]   LC_RESET  = LC_W'(MAX_LEAVES);
   localparam logic [ADDR_W-1:0] ROOT_ADDR = ADDR_W'(1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   typedef struct packed {
      logic [IDX_W-1:0]        leaf_index;
      logic signed [VAL_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] root_max;
      logic                    index_error;
   } rsp_type;

   // Store access issued by the walker in one cycle
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [VAL_W-1:0]  wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } ram_cmd_type;

   // Walker sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_CLIMB = 4'b0100,
      ST_ROOT  = 4'b1000
   } walk_state_type;

endpackage

// ===== src/max_segment_tree_point_update_unit.sv =====
// Max segment tree point update unit: one leaf write, then a climb to the root; a rejected
// index only reads the root. The climb updates one parent per level from the leaf's depth
// (floor log2 of the saturated leaf count plus leaf_index, up to 10) up to the root.
// A new transaction is accepted only when idle; the climb is bound by one sibling read per
// level on the single read port of the tree store. Results cannot be stalled by the receiver.
// Reset: synchronous; a clearing pass fills every store address while busy is high.
module max_segment_tree_point_update_unit import mstpu_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_type         req_item,
   output logic            rsp_strobe,
   output rsp_type         rsp_item,
   input  logic            csr_we,
   input  logic [LC_W-1:0] csr_wdata
);

   logic [LC_W-1:0]   leaf_count_ff;
   logic [ADDR_W-1:0] leaf_n;
   ram_cmd_type       ram_cmd;
   logic [VAL_W-1:0]  ram_rd_data;

   // Hold the leaf count register
   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_count_ff <= LC_RESET;
      end else if (csr_we) begin
         leaf_count_ff <= csr_wdata;
      end
   end

   // Saturate the count at the tree capacity
   assign leaf_n = (32'(leaf_count_ff) > 32'(MAX_LEAVES)) ? ADDR_W'(MAX_LEAVES)
                                                           : ADDR_W'(leaf_count_ff);

   mstpu_walk u_walk (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .leaf_n      (leaf_n),
      .ram_cmd     (ram_cmd),
      .ram_rd_data (ram_rd_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item)
   );

   mstpu_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (ram_cmd.wr_data),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== src/mstpu_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mstpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read on the same edge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mstpu_walk.sv =====
// Walker for the max segment tree: clearing pass, leaf write, climb to the root, root read on a rejected index.
// Depends on mstpu_pkg; drives the tree store through a ram_cmd_type bundle.
module mstpu_walk import mstpu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_item,
   input  logic [ADDR_W-1:0] leaf_n,
   output ram_cmd_type       ram_cmd,
   input  logic [VAL_W-1:0]  ram_rd_data,
   output logic              rsp_strobe,
   output rsp_type           rsp_item
);

   walk_state_type          state_ff, state_in;
   logic [ADDR_W-1:0]       pos_ff, pos_in;
   logic [ADDR_W-1:0]       clr_ff, clr_in;
   logic signed [VAL_W-1:0] cur_ff, cur_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    idx_bad;
   logic [ADDR_W-1:0]       leaf_pos;
   logic [ADDR_W-1:0]       par_pos;
   logic signed [VAL_W-1:0] sib_val;
   logic signed [VAL_W-1:0] parent_val;

   // Locate the leaf; an index at or beyond the count is rejected
   assign idx_bad  = (32'(req_item.leaf_index) >= 32'(leaf_n));
   assign leaf_pos = ADDR_W'(32'(leaf_n) + 32'(req_item.leaf_index));

   // Combine the running value with the sibling just read
   assign sib_val    = $signed(ram_rd_data);
   assign parent_val = (cur_ff < sib_val) ? sib_val : cur_ff;
   assign par_pos    = pos_ff >> 1;

   // Sequence the store accesses
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = clr_ff;
            ram_cmd.wr_data = VAL_MIN;
            clr_in          = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (idx_bad) begin
                  // Fetch the current root and report it unchanged
                  ram_cmd.rd_addr = ROOT_ADDR;
                  state_in        = ST_ROOT;
               end else begin
                  ram_cmd.wr_en   = 1'b1;
                  ram_cmd.wr_addr = leaf_pos;
                  ram_cmd.wr_data = req_item.new_value;
                  cur_in          = req_item.new_value;
                  pos_in          = leaf_pos;
                  if (leaf_pos == ROOT_ADDR) begin
                     // Single leaf: the leaf is the root
                     rsp_valid_in         = 1'b1;
                     rsp_in.root_max      = req_item.new_value;
                     rsp_in.index_error   = 1'b0;
                  end else begin
                     ram_cmd.rd_addr = leaf_pos ^ ADDR_W'(1);
                     state_in        = ST_CLIMB;
                  end
               end
            end
         end
         ST_CLIMB: begin
            // Write the parent and fetch the next sibling in the same cycle
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = par_pos;
            ram_cmd.wr_data = parent_val;
            cur_in          = parent_val;
            pos_in          = par_pos;
            if (par_pos == ROOT_ADDR) begin
               rsp_valid_in       = 1'b1;
               rsp_in.root_max    = parent_val;
               rsp_in.index_error = 1'b0;
               state_in           = ST_IDLE;
            end else begin
               ram_cmd.rd_addr = par_pos ^ ADDR_W'(1);
            end
         end
         ST_ROOT: begin
            rsp_valid_in       = 1'b1;
            rsp_in.root_max    = sib_val;
            rsp_in.index_error = 1'b1;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control state; clear the store after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Advance the datapath registers
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule
